// File: rtl/core/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared constants and types of the nearest palette color mapper.
// ----------------------------------------------------------------------------
package npcm_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int QUANT_BITS    = 6;

  localparam int ADDR_W  = $clog2(PALETTE_DEPTH);
  localparam int COUNT_W = $clog2(PALETTE_DEPTH + 1);

  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 8;
  localparam int DIST_W  = 18;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int WORD_W  = 4 * CHAN_W;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 9;

  // quantization cell of the color-only mode
  localparam int QSHIFT    = CHAN_W - QUANT_BITS;
  localparam int CELL_HALF = (1 << QSHIFT) / 2;

  localparam logic [CHAN_W-1:0] GREEN_MAX = 8'd255;

  localparam logic [DIST_W-1:0] MAX_DIST_RGBA = DIST_W'(4 * 255 * 255);
  localparam logic [DIST_W-1:0] MAX_DIST_RGB  = DIST_W'(3 * 255 * 255);

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_USE_ALPHA    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_SIZE = 8'd1;

  // command codes of the action field
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  // pixel reference point latched at the start of a map
  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] a;
    logic              use_alpha;
  } pixel_ref_t;

  function automatic logic [CHAN_W-1:0] cell_centre(input logic [CHAN_W-1:0] c);
    logic [CHAN_W-1:0] base;
    base = (c >> QSHIFT) << QSHIFT;
    return base + CHAN_W'(CELL_HALF);
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] x,
                                               input logic [CHAN_W-1:0] y);
    logic [CHAN_W-1:0] d;
    d = (x > y) ? (x - y) : (y - x);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

// File: rtl/core/nearest_palette_color_mapper.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper
// Palette store with a sequential nearest-entry search over its active range.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  --------  ----------------------  ----------------------------------------
//  command   start & !busy           action, entry_index, red, green, blue, alpha
//  result    done (one-cycle strobe) color_index, best_distance
//  config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
//  a load leaves busy low; a map holds busy through scan, drain and result,
//  scanning n entries (n the clamped palette_size) at one memory read per cycle
//  trailing pure-green entries are dropped on the fly, so one pass does the trim
//  reset clears control and configuration; palette contents are undefined
//  until loaded; the receiver cannot stall, done is high for exactly one cycle
//  configuration writes are always taken (cfg_ready is tied high)
module nearest_palette_color_mapper (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  action,
  input  logic [npcm_pkg::INDEX_W-1:0]          entry_index,
  input  logic [npcm_pkg::CHAN_W-1:0]           red,
  input  logic [npcm_pkg::CHAN_W-1:0]           green,
  input  logic [npcm_pkg::CHAN_W-1:0]           blue,
  input  logic [npcm_pkg::CHAN_W-1:0]           alpha,
  output logic                                  done,
  output logic [npcm_pkg::INDEX_W-1:0]          color_index,
  output logic [npcm_pkg::DIST_W-1:0]           best_distance,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [npcm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [npcm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t state;

  logic                             use_alpha;
  logic [npcm_pkg::COUNT_W-1:0]     palette_size;

  logic [npcm_pkg::WORD_W-1:0]      palette_mem [npcm_pkg::PALETTE_DEPTH];
  logic [npcm_pkg::WORD_W-1:0]      rd_data;
  logic [npcm_pkg::ADDR_W-1:0]      rd_addr;

  npcm_pkg::pixel_ref_t             px;
  logic [npcm_pkg::ADDR_W-1:0]      last_idx;
  logic [npcm_pkg::ADDR_W-1:0]      scan_cnt;

  // pipeline: address issue, square stage, accumulate stage
  logic                             p0_valid;
  logic                             p0_last;
  logic [npcm_pkg::ADDR_W-1:0]      p0_idx;

  logic                             s1_valid;
  logic                             s1_last;
  logic                             s1_green;
  logic [npcm_pkg::ADDR_W-1:0]      s1_idx;
  logic [npcm_pkg::SQ_W-1:0]        s1_sq [4];

  // best over entries up to the last non-green one, and over the green run after it
  logic [npcm_pkg::DIST_W-1:0]      comm_dist, comm_dist_next;
  logic [npcm_pkg::ADDR_W-1:0]      comm_idx, comm_idx_next;
  logic                             pend_valid, pend_valid_next;
  logic [npcm_pkg::DIST_W-1:0]      pend_dist, pend_dist_next;
  logic [npcm_pkg::ADDR_W-1:0]      pend_idx, pend_idx_next;

  logic                             cmd_take;
  logic [npcm_pkg::COUNT_W-1:0]     n_active;
  logic [npcm_pkg::DIST_W-1:0]      e_dist;
  logic [npcm_pkg::DIST_W-1:0]      merged_dist;
  logic [npcm_pkg::ADDR_W-1:0]      merged_idx;
  logic                             rd_green;

  assign cmd_take  = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      use_alpha    <= 1'b0;
      palette_size <= npcm_pkg::COUNT_W'(npcm_pkg::PALETTE_DEPTH);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        npcm_pkg::REG_USE_ALPHA:    use_alpha    <= cfg_data[0];
        npcm_pkg::REG_PALETTE_SIZE: begin
          if (cfg_data == '0) begin
            palette_size <= npcm_pkg::COUNT_W'(1);
          end else if (32'(cfg_data) > 32'(npcm_pkg::PALETTE_DEPTH)) begin
            palette_size <= npcm_pkg::COUNT_W'(npcm_pkg::PALETTE_DEPTH);
          end else begin
            palette_size <= npcm_pkg::COUNT_W'(cfg_data);
          end
        end
        default: ;
      endcase
    end
  end

  assign n_active = palette_size;

  // palette memory: one write port for loads, one registered read port
  assign rd_addr = scan_cnt;

  always_ff @(posedge clk) begin
    if (cmd_take && action == npcm_pkg::ACT_LOAD &&
        32'(entry_index) < 32'(npcm_pkg::PALETTE_DEPTH)) begin
      palette_mem[npcm_pkg::ADDR_W'(entry_index)] <= {alpha, blue, green, red};
    end
    rd_data <= palette_mem[rd_addr];
  end

  // pixel reference latched at map start
  always_ff @(posedge clk) begin
    if (cmd_take && action == npcm_pkg::ACT_MAP) begin
      px.use_alpha <= use_alpha;
      px.a         <= alpha;
      if (use_alpha) begin
        px.r <= red;
        px.g <= green;
        px.b <= blue;
      end else begin
        px.r <= npcm_pkg::cell_centre(red);
        px.g <= npcm_pkg::cell_centre(green);
        px.b <= npcm_pkg::cell_centre(blue);
      end
      last_idx <= npcm_pkg::ADDR_W'(n_active - npcm_pkg::COUNT_W'(1));
    end
  end

  // square stage
  assign rd_green = (rd_data[7:0] == '0) && (rd_data[15:8] == npcm_pkg::GREEN_MAX) &&
                    (rd_data[23:16] == '0);

  always_ff @(posedge clk) begin
    s1_sq[0] <= npcm_pkg::sq_diff(rd_data[7:0],   px.r);
    s1_sq[1] <= npcm_pkg::sq_diff(rd_data[15:8],  px.g);
    s1_sq[2] <= npcm_pkg::sq_diff(rd_data[23:16], px.b);
    s1_sq[3] <= px.use_alpha ? npcm_pkg::sq_diff(rd_data[31:24], px.a) : '0;
    s1_idx   <= p0_idx;
    s1_last  <= p0_last;
    s1_green <= rd_green && (p0_idx != '0);
  end

  // accumulate stage
  assign e_dist = npcm_pkg::DIST_W'(s1_sq[0]) + npcm_pkg::DIST_W'(s1_sq[1]) +
                  npcm_pkg::DIST_W'(s1_sq[2]) + npcm_pkg::DIST_W'(s1_sq[3]);

  always_comb begin
    // a green run only counts once a later non-green entry closes it
    if (pend_valid && pend_dist < comm_dist) begin
      merged_dist = pend_dist;
      merged_idx  = pend_idx;
    end else begin
      merged_dist = comm_dist;
      merged_idx  = comm_idx;
    end
    comm_dist_next  = comm_dist;
    comm_idx_next   = comm_idx;
    pend_valid_next = pend_valid;
    pend_dist_next  = pend_dist;
    pend_idx_next   = pend_idx;
    priority if (s1_idx == '0) begin
      comm_dist_next  = e_dist;
      comm_idx_next   = '0;
      pend_valid_next = 1'b0;
    end else if (s1_green) begin
      if (!pend_valid || e_dist < pend_dist) begin
        pend_dist_next = e_dist;
        pend_idx_next  = s1_idx;
      end
      pend_valid_next = 1'b1;
    end else begin
      if (e_dist < merged_dist) begin
        comm_dist_next = e_dist;
        comm_idx_next  = s1_idx;
      end else begin
        comm_dist_next = merged_dist;
        comm_idx_next  = merged_idx;
      end
      pend_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      comm_dist  <= comm_dist_next;
      comm_idx   <= comm_idx_next;
      pend_valid <= pend_valid_next;
      pend_dist  <= pend_dist_next;
      pend_idx   <= pend_idx_next;
    end
  end

  // sequencer with registered result outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
      p0_valid <= 1'b0;
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      p0_valid <= 1'b0;
      s1_valid <= p0_valid;
      unique case (state)
        ST_IDLE: begin
          scan_cnt <= '0;
          if (cmd_take && action == npcm_pkg::ACT_MAP) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          p0_valid <= 1'b1;
          p0_idx   <= scan_cnt;
          p0_last  <= (scan_cnt == last_idx);
          if (scan_cnt == last_idx) begin
            state <= ST_DRAIN;
          end else begin
            scan_cnt <= scan_cnt + npcm_pkg::ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          if (s1_valid && s1_last) begin
            state         <= ST_RESULT;
            done          <= 1'b1;
            color_index   <= npcm_pkg::INDEX_W'(comm_idx_next);
            best_distance <= comm_dist_next;
          end
        end
        ST_RESULT: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a map");

  a_map_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == npcm_pkg::ACT_MAP) |=> busy)
    else $error("map transfer did not start a scan");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == npcm_pkg::ACT_LOAD) |=> !busy)
    else $error("palette load held the block busy");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (best_distance <= npcm_pkg::MAX_DIST_RGBA) &&
             (px.use_alpha || best_distance <= npcm_pkg::MAX_DIST_RGB))
    else $error("best distance out of range for the mode");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

// File: dv/nearest_palette_color_mapper_tb.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_tb
// Loads palettes and maps pixels through the command port. Every map result
// is checked against a directed table value or a behavioral nearest-entry search.
// A directed table comes first, then randomized phases under varying modes and
// palette sizes, each phase filling the active range before any pixel is mapped.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npcm_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 300;
  localparam int RANDOM_PHASES = 12;
  localparam int TIMEOUT_NS    = 30_000_000;

  // register indexes outside the map, writes to them must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 8'hFF;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] a;
  } rgba_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  distance;
  } match_t;

  typedef enum logic {ROW_CMD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic                    action;
    logic [INDEX_W-1:0]      slot;
    rgba_t                   color;
    logic [CFG_INDEX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0]   reg_data;
    bit                      typed;
    match_t                  want;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    action;
  logic [INDEX_W-1:0]      entry_index;
  logic [CHAN_W-1:0]       red;
  logic [CHAN_W-1:0]       green;
  logic [CHAN_W-1:0]       blue;
  logic [CHAN_W-1:0]       alpha;
  logic                    done;
  logic [INDEX_W-1:0]      color_index;
  logic [DIST_W-1:0]       best_distance;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  nearest_palette_color_mapper u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .entry_index   (entry_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .done          (done),
    .color_index   (color_index),
    .best_distance (best_distance),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // mirror of the block state
  rgba_t                  palette_mirror [PALETTE_DEPTH];
  bit                     slot_loaded [PALETTE_DEPTH];
  bit                     alpha_mode;
  logic [CFG_DATA_W-1:0]  size_setting;

  match_t     expected_matches [$];
  stim_row_t  directed_rows [$];

  int unsigned failures;
  int unsigned loads_sent;
  int unsigned maps_sent;
  int unsigned results_checked;
  int unsigned reg_writes;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d map results outstanding", expected_matches.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned active_limit(input logic [CFG_DATA_W-1:0] size_word);
    if (size_word == 0) return 1;
    if (size_word > PALETTE_DEPTH) return PALETTE_DEPTH;
    return size_word;
  endfunction

  function automatic int unsigned chan_sq(input logic [CHAN_W-1:0] x,
                                          input logic [CHAN_W-1:0] y);
    int d;
    d = int'(x) - int'(y);
    return d * d;
  endfunction

  // nearest active entry for a pixel under the current mode and size
  function automatic match_t nearest_entry(input rgba_t px);
    int unsigned last;
    int unsigned cost;
    int unsigned best;
    rgba_t       ref_pt;
    rgba_t       e;
    match_t      m;
    last = active_limit(size_setting) - 1;
    // trailing pure green entries drop out, entry 0 never does
    while (last > 0 && palette_mirror[last].r == 0 && palette_mirror[last].g == GREEN_MAX &&
           palette_mirror[last].b == 0)
      last--;
    ref_pt = px;
    if (!alpha_mode) begin
      ref_pt.r = 8'(((px.r >> QSHIFT) << QSHIFT) + CELL_HALF);
      ref_pt.g = 8'(((px.g >> QSHIFT) << QSHIFT) + CELL_HALF);
      ref_pt.b = 8'(((px.b >> QSHIFT) << QSHIFT) + CELL_HALF);
    end
    best = 32'h7FFF_FFFF;
    m = '0;
    for (int unsigned i = 0; i <= last; i++) begin
      e = palette_mirror[i];
      cost = chan_sq(e.r, ref_pt.r) + chan_sq(e.g, ref_pt.g) + chan_sq(e.b, ref_pt.b);
      if (alpha_mode) cost += chan_sq(e.a, px.a);
      if (cost < best) begin
        best = cost;
        m.index = i[INDEX_W-1:0];
      end
    end
    m.distance = best[DIST_W-1:0];
    return m;
  endfunction

  function automatic stim_row_t cmd_row(input logic act, input logic [INDEX_W-1:0] slot,
                                        input rgba_t color);
    stim_row_t row;
    row = '{kind: ROW_CMD, action: act, slot: slot, color: color, reg_index: '0,
            reg_data: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t map_row(input rgba_t color, input logic [INDEX_W-1:0] idx,
                                        input logic [DIST_W-1:0] distance);
    stim_row_t row;
    row = cmd_row(ACT_MAP, 8'hFF, color);
    row.typed = 1'b1;
    row.want = '{index: idx, distance: distance};
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = cmd_row(ACT_LOAD, '0, '0);
    row.kind = ROW_REG;
    row.reg_index = idx;
    row.reg_data = data;
    return row;
  endfunction

  // palette content biased toward green trims, near misses and ties
  function automatic rgba_t random_entry(input int unsigned n);
    rgba_t       c;
    int unsigned j;
    c = rgba_t'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        c.r = 0;
        c.g = GREEN_MAX;
        c.b = 0;
      end
      3: begin
        c.r = 0;
        c.g = GREEN_MAX;
        c.b = 0;
        case ($urandom_range(0, 2))
          0: c.r = 1;
          1: c.g = GREEN_MAX - 1;
          default: c.b = 1;
        endcase
      end
      4, 5: begin
        j = $urandom_range(0, n - 1);
        if (slot_loaded[j]) c = palette_mirror[j];
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic issue_command(input logic act, input logic [INDEX_W-1:0] slot,
                               input rgba_t color, input int unsigned gap,
                               input bit typed, input match_t want);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start       <= 1'b1;
    action      <= act;
    entry_index <= slot;
    red         <= color.r;
    green       <= color.g;
    blue        <= color.b;
    alpha       <= color.a;
    do @(posedge clk); while (busy);
    // transfer taken at this edge
    if (act == ACT_LOAD) begin
      palette_mirror[slot] = color;
      slot_loaded[slot] = 1'b1;
      loads_sent++;
    end else begin
      expected_matches.push_back(typed ? want : nearest_entry(color));
      maps_sent++;
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    start <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    // a load leaves nothing to wait for, give it time to retire
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_USE_ALPHA) alpha_mode = data[0];
    else if (idx == REG_PALETTE_SIZE) size_setting = data;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    match_t want;
    if (!rst && done) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result: color_index %0d best_distance %0d",
               color_index, best_distance);
        failures++;
      end else begin
        want = expected_matches.pop_front();
        results_checked++;
        if (color_index !== want.index) begin
          $error("color_index mismatch: expected %0d, got %0d", want.index, color_index);
          failures++;
        end
        if (best_distance !== want.distance) begin
          $error("best_distance mismatch: expected %0d, got %0d",
                 want.distance, best_distance);
          failures++;
        end
      end
    end
  end

  initial begin
    stim_row_t             row;
    rgba_t                 color;
    logic [INDEX_W-1:0]    slot;
    logic [CFG_DATA_W-1:0] size_word;
    int unsigned           n;
    int unsigned           items;
    int unsigned           tail;
    int unsigned           roll;
    int unsigned           j;
    bit                    burst;

    rst         = 1'b1;
    start       = 1'b0;
    action      = ACT_LOAD;
    entry_index = '0;
    red         = '0;
    green       = '0;
    blue        = '0;
    alpha       = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    alpha_mode   = 1'b0;
    size_setting = 9'd256;
    failures = 0;
    loads_sent = 0;
    maps_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    foreach (palette_mirror[i]) begin
      palette_mirror[i] = '0;
      slot_loaded[i] = 1'b0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_rows = '{
      reg_row(REG_PALETTE_SIZE, 9'd4),
      cmd_row(ACT_LOAD, 8'd0, '{8'd0, 8'd0, 8'd0, 8'd0}),
      cmd_row(ACT_LOAD, 8'd1, '{8'd255, 8'd255, 8'd255, 8'd255}),
      cmd_row(ACT_LOAD, 8'd2, '{8'd0, 8'd255, 8'd0, 8'd0}),
      cmd_row(ACT_LOAD, 8'd3, '{8'd0, 8'd255, 8'd0, 8'd255}),
      map_row('{8'd0, 8'd0, 8'd0, 8'd0}, 8'd0, 18'd12),
      map_row('{8'd255, 8'd255, 8'd255, 8'd255}, 8'd1, 18'd3),
      // both green tail entries trimmed, so the exact green pixel cannot hit
      map_row('{8'd0, 8'd255, 8'd0, 8'd0}, 8'd0, 18'd64524),
      cmd_row(ACT_LOAD, 8'd3, '{8'd0, 8'd255, 8'd1, 8'd0}),
      cmd_row(ACT_MAP, 8'd0, '{8'd0, 8'd255, 8'd0, 8'd0}),
      reg_row(REG_USE_ALPHA, 9'h1FF),
      map_row('{8'd255, 8'd255, 8'd255, 8'd255}, 8'd1, 18'd0),
      map_row('{8'd0, 8'd0, 8'd0, 8'd0}, 8'd0, 18'd0),
      map_row('{8'd0, 8'd255, 8'd0, 8'd0}, 8'd2, 18'd0),
      reg_row(REG_PALETTE_SIZE, 9'd0),
      map_row('{8'd255, 8'd255, 8'd255, 8'd255}, 8'd0, 18'd260100),
      reg_row(REG_USE_ALPHA, 9'h100),
      map_row('{8'd255, 8'd255, 8'd255, 8'd0}, 8'd0, 18'd193548),
      // a lone green entry 0 stays active
      cmd_row(ACT_LOAD, 8'd0, '{8'd0, 8'd255, 8'd0, 8'd77}),
      map_row('{8'd0, 8'd0, 8'd0, 8'd0}, 8'd0, 18'd64017),
      reg_row(REG_UNUSED_LO, 9'h1FF),
      reg_row(REG_UNUSED_HI, 9'h000),
      map_row('{8'd0, 8'd0, 8'd0, 8'd0}, 8'd0, 18'd64017),
      cmd_row(ACT_LOAD, 8'd255, '{8'd255, 8'd0, 8'd255, 8'd0}),
      reg_row(REG_PALETTE_SIZE, 9'd2),
      cmd_row(ACT_MAP, 8'd0, '{8'd131, 8'd126, 8'd3, 8'd200})
    };

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_REG) write_register(row.reg_index, row.reg_data);
      else issue_command(row.action, row.slot, row.color, $urandom_range(0, 9),
                         row.typed, row.want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 3 == 2)
        write_register(8'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                       9'($urandom_range(0, 511)));
      write_register(REG_USE_ALPHA, 9'(($urandom_range(0, 511) & 9'h1FE) |
                     ((p < 2) ? p % 2 : $urandom_range(0, 1))));
      case (p)
        0: size_word = 9'd256;
        1: size_word = 9'd1;
        2: size_word = 9'd0;
        3: size_word = 9'h1FF;
        4: size_word = 9'd300;
        default: size_word = ($urandom_range(0, 7) == 0) ? 9'd256 : 9'($urandom_range(2, 24));
      endcase
      write_register(REG_PALETTE_SIZE, size_word);
      n = active_limit(size_word);
      tail = (n > 4) ? 3 : n - 1;
      burst = ($urandom_range(0, 3) == 0);

      // every active slot holds data before the first map of the phase
      for (int unsigned i = 0; i < n; i++)
        if (!slot_loaded[i])
          issue_command(ACT_LOAD, 8'(i), random_entry(n), burst ? 0 : $urandom_range(0, 9),
                        1'b0, '0);

      items = (n > 64) ? 30 : 90;
      for (int unsigned k = 0; k < items; k++) begin
        color = rgba_t'($urandom);
        if ($urandom_range(0, 99) < 68) begin
          roll = $urandom_range(0, 3);
          if (roll == 1) begin
            j = $urandom_range(0, n - 1);
            color = palette_mirror[j] ^ rgba_t'($urandom & 32'h0303_0303);
          end else if (roll == 2) begin
            if ($urandom_range(0, 2) == 0) color.r = 0; else if ($urandom_range(0, 1)) color.r = 255;
            if ($urandom_range(0, 2) == 0) color.g = 0; else if ($urandom_range(0, 1)) color.g = 255;
            if ($urandom_range(0, 2) == 0) color.b = 0; else if ($urandom_range(0, 1)) color.b = 255;
            if ($urandom_range(0, 2) == 0) color.a = 0; else if ($urandom_range(0, 1)) color.a = 255;
          end
          issue_command(ACT_MAP, 8'($urandom), color, burst ? 0 : $urandom_range(0, 9),
                        1'b0, '0);
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 40) slot = 8'(n - 1 - $urandom_range(0, tail));
          else if (roll < 75) slot = 8'($urandom_range(0, n - 1));
          else slot = 8'($urandom_range(0, 255));
          issue_command(ACT_LOAD, slot, random_entry(n), burst ? 0 : $urandom_range(0, 9),
                        1'b0, '0);
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d palette loads and %0d pixel maps, %0d results checked,",
             loads_sent, maps_sent, results_checked);
    $display("over %0d register writes spanning both search modes and sizes 1 to 256",
             reg_writes);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/npcm_pkg.sv
rtl/core/nearest_palette_color_mapper.sv
dv/nearest_palette_color_mapper_tb.sv
